### rtl/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared constants and controller/datapath link types for the frustum
// plane extractor.
// ----------------------------------------------------------------------------
package fpe_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int ROW_COUNT   = 3;
   localparam int ELEM_COUNT  = 4;
   localparam int SQRT_STEPS  = WORD_BITS;
   localparam int NUM_BITS    = WORD_BITS + FRAC_BITS;
   localparam int DIV_STEPS   = NUM_BITS / 2;

   localparam logic [1:0] ROW_TRIGGER = 2'd3;
   localparam logic [2:0] PLANE_FAR   = 3'd5;
   localparam logic [1:0] ELEM_LAST   = 2'd3;

   typedef struct packed {
      logic       req_ready;
      logic       read_row;
      logic [1:0] row_sel;
      logic       sum;
      logic       sub;
      logic       sq_mul;
      logic       sq_acc;
      logic [1:0] sel;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_fin;
      logic       emit;
      logic [2:0] plane;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_trigger;
      logic len_zero;
      logic out_free;
   } sts_type;

endpackage

### rtl/fpe_if.sv
// ----------------------------------------------------------------------------
// fpe_req_if / fpe_rsp_if
// Valid/ready channels carrying matrix rows in and plane words out.
// ----------------------------------------------------------------------------
interface fpe_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         row_index;
   logic signed [31:0] elem_x;
   logic signed [31:0] elem_y;
   logic signed [31:0] elem_z;
   logic signed [31:0] elem_w;

   modport source (output valid, row_index, elem_x, elem_y, elem_z, elem_w,
                   input ready);
   modport sink   (input valid, row_index, elem_x, elem_y, elem_z, elem_w,
                   output ready);
endinterface

interface fpe_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         plane_index;
   logic signed [31:0] coef_a;
   logic signed [31:0] coef_b;
   logic signed [31:0] coef_c;
   logic signed [31:0] coef_d;
   logic               last_plane;

   modport source (output valid, plane_index, coef_a, coef_b, coef_c, coef_d,
                   last_plane, input ready);
   modport sink   (input valid, plane_index, coef_a, coef_b, coef_c, coef_d,
                   last_plane, output ready);
endinterface

### rtl/fpe_ctrl.sv
// ----------------------------------------------------------------------------
// fpe_ctrl
// Sequencer: per plane it steps read, sum, squares, square root,
// four divisions (skipped for a zero-length plane) and the output load.
// ----------------------------------------------------------------------------
module fpe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  fpe_pkg::sts_type sts,
   output fpe_pkg::cmd_type cmd
);
   import fpe_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_READ      = 4'd1;
   localparam logic [3:0] S_SUM       = 4'd2;
   localparam logic [3:0] S_SQ        = 4'd3;
   localparam logic [3:0] S_SQRT_INIT = 4'd4;
   localparam logic [3:0] S_SQRT      = 4'd5;
   localparam logic [3:0] S_DIV_INIT  = 4'd6;
   localparam logic [3:0] S_DIV       = 4'd7;
   localparam logic [3:0] S_DIV_FIN   = 4'd8;
   localparam logic [3:0] S_OUT       = 4'd9;

   localparam logic [4:0] SQRT_END = 5'(SQRT_STEPS - 1);
   localparam logic [4:0] DIV_END  = 5'(DIV_STEPS - 1);

   logic [3:0] state_ff, state_in;
   logic [2:0] plane_ff, plane_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] coef_ff, coef_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         plane_ff <= '0;
         cnt_ff   <= '0;
         coef_ff  <= '0;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         cnt_ff   <= cnt_in;
         coef_ff  <= coef_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      cnt_in   = cnt_ff;
      coef_in  = coef_ff;
      cmd      = '0;
      cmd.row_sel = plane_ff[2:1];
      cmd.sub     = plane_ff[0];
      cmd.plane   = plane_ff;
      cmd.last    = (plane_ff == PLANE_FAR);
      cmd.sel     = coef_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid && sts.req_trigger) begin
               plane_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read_row = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            cnt_in   = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.sel    = cnt_ff[1:0];
            cmd.sq_mul = (cnt_ff[1:0] != ELEM_LAST);
            cmd.sq_acc = (cnt_ff != '0);
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff[1:0] == ELEM_LAST) begin
               state_in = S_SQRT_INIT;
            end
         end
         S_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            coef_in       = '0;
            if (cnt_ff == SQRT_END) begin
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            if (sts.len_zero) begin
               state_in = S_OUT;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == DIV_END) begin
               state_in = S_DIV_FIN;
            end
         end
         S_DIV_FIN: begin
            cmd.div_fin = 1'b1;
            if (coef_ff == ELEM_LAST) begin
               state_in = S_OUT;
            end else begin
               coef_in  = coef_ff + 2'd1;
               state_in = S_DIV_INIT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (plane_ff == PLANE_FAR) begin
                  state_in = S_IDLE;
               end else begin
                  plane_in = plane_ff + 3'd1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/fpe_dp.sv
// ----------------------------------------------------------------------------
// fpe_dp
// Row store, plane sums, sum of squares, bit-serial square root,
// radix-4 restoring divider and output word register.
// ----------------------------------------------------------------------------
module fpe_dp (
   input  logic             clock,
   input  logic             reset,
   input  fpe_pkg::cmd_type cmd,
   output fpe_pkg::sts_type sts,
   fpe_req_if.sink          req,
   fpe_rsp_if.source        rsp
);
   import fpe_pkg::*;

   localparam int RW = 4 * WORD_BITS;

   logic [RW-1:0]        row_mem [0:ROW_COUNT-1];
   logic [RW-1:0]        src_ff;
   logic [WORD_BITS-1:0] e_ff [0:ELEM_COUNT-1];
   logic [WORD_BITS-1:0] p_ff [0:ELEM_COUNT-1];
   logic [WORD_BITS-1:0] res_ff [0:ELEM_COUNT-1];
   logic [2*WORD_BITS-1:0] prod_ff, acc_ff, rad_ff;
   logic [WORD_BITS+1:0]   srem_ff;
   logic [WORD_BITS-1:0]   root_ff;
   logic [NUM_BITS-1:0]    num_ff, quo_ff;
   logic [WORD_BITS-1:0]   drem_ff;

   logic                   rsp_valid_ff;
   logic [2:0]             rsp_plane_ff;
   logic                   rsp_last_ff;
   logic [WORD_BITS-1:0]   rsp_coef_ff [0:ELEM_COUNT-1];

   logic                   take;
   logic [RW-1:0]          req_row;
   logic [WORD_BITS-1:0]   sel_p, sel_mag;
   logic [WORD_BITS+3:0]   sr_sh;
   logic [WORD_BITS+1:0]   sr_trial;
   logic [WORD_BITS-1:0]   d_r1, d_r2;
   logic                   d_q1, d_q2;
   logic [NUM_BITS-1:0]    q_lim, q_sat;

   function automatic logic [WORD_BITS-1:0] sat_sum(input logic [WORD_BITS-1:0] a,
                                                    input logic [WORD_BITS-1:0] b,
                                                    input logic sub);
      logic [WORD_BITS:0] s;
      s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
              : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                             : {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return s[WORD_BITS-1:0];
   endfunction

   function automatic logic [WORD_BITS:0] div_bit(input logic [WORD_BITS-1:0] r,
                                                  input logic b,
                                                  input logic [WORD_BITS-1:0] d);
      logic [WORD_BITS:0] r2;
      r2 = {r, b};
      if (r2 >= {1'b0, d}) begin
         r2 = r2 - {1'b0, d};
         return {1'b1, r2[WORD_BITS-1:0]};
      end
      return {1'b0, r2[WORD_BITS-1:0]};
   endfunction

   assign take    = req.valid && cmd.req_ready;
   assign req.ready = cmd.req_ready;
   assign req_row = {req.elem_w, req.elem_z, req.elem_y, req.elem_x};

   assign sts.req_valid   = req.valid;
   assign sts.req_trigger = (req.row_index == ROW_TRIGGER);
   assign sts.len_zero    = (root_ff == '0);
   assign sts.out_free    = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (take && (req.row_index != ROW_TRIGGER)) begin
         row_mem[req.row_index] <= req_row;
      end
      if (cmd.read_row) begin
         src_ff <= row_mem[cmd.row_sel];
      end
   end

   assign sel_p   = p_ff[cmd.sel];
   assign sel_mag = sel_p[WORD_BITS-1] ? (~sel_p + 1'b1) : sel_p;

   assign sr_sh    = {srem_ff, rad_ff[2*WORD_BITS-1 -: 2]};
   assign sr_trial = {root_ff, 2'b01};

   always_comb begin
      logic [WORD_BITS:0] t1, t2;
      t1   = div_bit(drem_ff, num_ff[NUM_BITS-1], root_ff);
      d_q1 = t1[WORD_BITS];
      d_r1 = t1[WORD_BITS-1:0];
      t2   = div_bit(d_r1, num_ff[NUM_BITS-2], root_ff);
      d_q2 = t2[WORD_BITS];
      d_r2 = t2[WORD_BITS-1:0];
   end

   assign q_lim = sel_p[WORD_BITS-1] ? NUM_BITS'({1'b1, {(WORD_BITS-1){1'b0}}})
                                     : NUM_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
   assign q_sat = (quo_ff > q_lim) ? q_lim : quo_ff;

   always_ff @(posedge clock) begin
      if (take && (req.row_index == ROW_TRIGGER)) begin
         e_ff[0] <= req.elem_x;
         e_ff[1] <= req.elem_y;
         e_ff[2] <= req.elem_z;
         e_ff[3] <= req.elem_w;
      end
      if (cmd.sum) begin
         for (int j = 0; j < ELEM_COUNT; j++) begin
            p_ff[j] <= sat_sum(e_ff[j], src_ff[j*WORD_BITS +: WORD_BITS], cmd.sub);
         end
         acc_ff <= '0;
      end
      if (cmd.sq_mul) begin
         prod_ff <= sel_mag * sel_mag;
      end
      if (cmd.sq_acc) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.sqrt_init) begin
         rad_ff  <= acc_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[2*WORD_BITS-3:0], 2'b00};
         if (sr_sh >= {2'b00, sr_trial}) begin
            srem_ff <= (WORD_BITS+2)'(sr_sh - {2'b00, sr_trial});
            root_ff <= {root_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            srem_ff <= sr_sh[WORD_BITS+1:0];
            root_ff <= {root_ff[WORD_BITS-2:0], 1'b0};
         end
      end
      if (cmd.div_init) begin
         num_ff  <= {sel_mag, {FRAC_BITS{1'b0}}};
         drem_ff <= '0;
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         num_ff  <= {num_ff[NUM_BITS-3:0], 2'b00};
         drem_ff <= d_r2;
         quo_ff  <= {quo_ff[NUM_BITS-3:0], d_q1, d_q2};
      end
      if (cmd.div_fin) begin
         res_ff[cmd.sel] <= sel_p[WORD_BITS-1] ? (~q_sat[WORD_BITS-1:0] + 1'b1)
                                               : q_sat[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_plane_ff <= cmd.plane;
         rsp_last_ff  <= cmd.last;
         for (int j = 0; j < ELEM_COUNT; j++) begin
            rsp_coef_ff[j] <= sts.len_zero ? p_ff[j] : res_ff[j];
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.plane_index = rsp_plane_ff;
   assign rsp.last_plane  = rsp_last_ff;
   assign rsp.coef_a      = rsp_coef_ff[0];
   assign rsp.coef_b      = rsp_coef_ff[1];
   assign rsp.coef_c      = rsp_coef_ff[2];
   assign rsp.coef_d      = rsp_coef_ff[3];

`ifndef SYNTHESIS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp.ready))
      else $error("word loaded over a pending word");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("loaded word not presented");
   a_last_far: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_plane_ff == PLANE_FAR))
      else $error("last flag on a plane other than far");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.sqrt_step || cmd.div_step) |-> !take)
      else $error("word taken while computing");
`endif

endmodule

### rtl/frustum_plane_extractor.sv
// ----------------------------------------------------------------------------
// frustum_plane_extractor
// Extracts six normalized frustum planes from a view-projection matrix.
// ----------------------------------------------------------------------------
// Input words carry one matrix row each (row_index 0..3, Q16.16 elements).
// Rows 0..2 are written to the row store. A row 3 word starts plane output:
// six words, left, right, bottom, top, near, far; last_plane marks far.
// Per plane: row read, sum, squares, square root (one bit per cycle),
// then per coefficient a radix-4 divider pass of 24 steps, and the
// output load; the root and divider unit is shared. Zero-length planes skip
// the divider. Input is taken only while no row 3 word is in progress.
// The output word sits in a register; when the receiver stalls, the next
// plane waits finished in the datapath and the sequencer holds.
// Reset (synchronous) clears the sequencer and the output valid; stored
// rows are kept and must be written before the first row 3 word.
// ----------------------------------------------------------------------------
module frustum_plane_extractor (
   input  logic      clock,
   input  logic      reset,
   fpe_req_if.sink   req_if,
   fpe_rsp_if.source rsp_if
);
   import fpe_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fpe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   fpe_dp u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req_if),
      .rsp   (rsp_if)
   );

endmodule
